@@ rtl/core/rtfg_pkg.sv @@
// Shared types and constants for the region table free gap finder.
`timescale 1ns / 1ps
package rtfg_pkg;

    localparam int DEF_MAX_REGIONS = 16;
    localparam int DEF_PAGE_BYTES  = 4096;

    typedef enum logic [1:0] {
        OP_ATTACH = 2'd0,
        OP_DETACH = 2'd1,
        OP_FIND   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // One stored region
    typedef struct packed {
        logic [31:0] base_addr;
        logic [31:0] limit_addr;
        logic [31:0] kind;
        logic [15:0] object;
        logic [31:0] offset;
    } entry_t;

endpackage

@@ rtl/core/rtfg_mem.sv @@
// Region entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module rtfg_mem #(
    parameter int DEPTH = rtfg_pkg::DEF_MAX_REGIONS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  rtfg_pkg::entry_t      wdata,
    input  logic [AW-1:0]         raddr,
    output rtfg_pkg::entry_t      rdata
);
    import rtfg_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/region_table_free_gap_finder_core.sv @@
// Channel   | Signals                                   | Direction
// input     | in_valid, in_stall, opcode .. req length  | item in, stall out
// output    | out_valid, out_stall, ok, found_addr, ... | result out, stall in
//
// Attach and unused opcodes go from S_IDLE straight to S_DONE; detach reads every
// entry, then passes S_DET_TAIL and S_DET_FIN. Find free is bound by the single
// read port of the entry memory: each candidate span reads every entry once.
// Reset clears valid bits, ranks and control; entry data is left as is.
// One item is worked at a time; in_stall is high while an item is in work.
// A result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
module region_table_free_gap_finder_core #(
    parameter int MAX_REGIONS = rtfg_pkg::DEF_MAX_REGIONS,
    parameter int PAGE_BYTES  = rtfg_pkg::DEF_PAGE_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] region_start,
    input  logic [31:0] region_end,
    input  logic [31:0] region_kind,
    input  logic [15:0] object_id,
    input  logic [31:0] object_offset,
    input  logic [31:0] request_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [31:0] found_addr,
    output logic [15:0] released_object
);
    import rtfg_pkg::*;

    localparam int AW = $clog2(MAX_REGIONS);
    localparam logic [AW-1:0] LAST = AW'(MAX_REGIONS - 1);
    localparam logic [32:0] PG_ADD  = 33'(PAGE_BYTES - 1);
    localparam logic [32:0] PG_MASK = ~33'(PAGE_BYTES - 1);
    localparam logic [32:0] PG_LEN  = 33'(PAGE_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_DET_SCAN, S_DET_TAIL, S_DET_FIN,
        S_FF_OUTER, S_FF_WAIT, S_FF_INNER, S_FF_TAIL, S_FF_EVAL, S_DONE
    } state_t;

    state_t               state_reg;
    logic [MAX_REGIONS-1:0] valid_reg;
    logic [AW-1:0]        rank_reg [MAX_REGIONS];
    logic [AW-1:0]        i_reg, j_reg, chk_idx_reg;
    logic                 chk_vld_reg;
    logic [31:0]          start_reg, lo_reg, hi_reg, best_reg;
    logic [32:0]          len_reg;
    logic                 clear_reg;
    logic                 hit_reg;
    logic [AW-1:0]        hit_idx_reg, hit_rank_reg;
    logic [15:0]          hit_obj_reg;
    logic                 p_ok_reg;
    logic [31:0]          p_addr_reg;
    logic [15:0]          p_rel_reg;
    logic                 res_valid_reg, res_ok_reg;
    logic [31:0]          res_addr_reg;
    logic [15:0]          res_rel_reg;

    logic                 accept;
    logic                 free_found;
    logic [AW-1:0]        free_idx;
    logic                 mem_we;
    logic [AW-1:0]        raddr;
    entry_t               wdata, rdata;
    logic [32:0]          len_in, len_rnd;
    logic                 collide;
    logic                 res_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign res_free = !res_valid_reg || !out_stall;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = MAX_REGIONS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_found = 1'b1;
                free_idx   = AW'(k);
            end
        end
    end

    // length rounded up to whole pages, zero counts as one page
    assign len_in  = (request_length == 32'd0) ? PG_LEN : {1'b0, request_length};
    assign len_rnd = (len_in + PG_ADD) & PG_MASK;

    // memory ports
    assign mem_we = accept && (opcode == OP_ATTACH) && free_found;
    assign wdata  = '{base_addr: region_start, limit_addr: region_end,
                      kind: region_kind, object: object_id, offset: object_offset};
    assign raddr  = (state_reg == S_FF_OUTER) ? i_reg : j_reg;

    rtfg_mem #(.DEPTH(MAX_REGIONS), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (free_idx),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // span test against the entry returned this cycle
    assign collide = !((rdata.base_addr < lo_reg && rdata.limit_addr < lo_reg) ||
                       (rdata.base_addr > hi_reg && rdata.limit_addr > hi_reg));

    // control, table bookkeeping and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            for (int k = 0; k < MAX_REGIONS; k++)
            begin
                rank_reg[k] <= '0;
            end
            i_reg         <= '0;
            j_reg         <= '0;
            chk_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            start_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            best_reg      <= '0;
            len_reg       <= '0;
            clear_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            hit_rank_reg  <= '0;
            hit_obj_reg   <= '0;
            p_ok_reg      <= 1'b0;
            p_addr_reg    <= '0;
            p_rel_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_ok_reg    <= 1'b0;
            res_addr_reg  <= '0;
            res_rel_reg   <= '0;
        end
        else
        begin
            // output register drains on transfer unless a new result loads
            if (res_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                res_valid_reg <= 1'b0;
            end

            // returned entry, checked in the cycle after its read
            chk_vld_reg <= 1'b0;
            if (chk_vld_reg && valid_reg[chk_idx_reg])
            begin
                if (state_reg == S_DET_SCAN || state_reg == S_DET_TAIL)
                begin
                    if (rdata.base_addr == start_reg &&
                        (!hit_reg || rank_reg[chk_idx_reg] < hit_rank_reg))
                    begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= chk_idx_reg;
                        hit_rank_reg <= rank_reg[chk_idx_reg];
                        hit_obj_reg  <= rdata.object;
                    end
                end
                else if (collide)
                begin
                    clear_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        start_reg  <= region_start;
                        len_reg    <= len_rnd;
                        hit_reg    <= 1'b0;
                        best_reg   <= '0;
                        i_reg      <= '0;
                        j_reg      <= '0;
                        p_ok_reg   <= 1'b0;
                        p_addr_reg <= '0;
                        p_rel_reg  <= '0;
                        unique case (opcode)
                            OP_ATTACH:
                            begin
                                if (free_found)
                                begin
                                    for (int k = 0; k < MAX_REGIONS; k++)
                                    begin
                                        if (valid_reg[k])
                                        begin
                                            rank_reg[k] <= rank_reg[k] + 1'b1;
                                        end
                                    end
                                    rank_reg[free_idx]  <= '0;
                                    valid_reg[free_idx] <= 1'b1;
                                    p_ok_reg            <= 1'b1;
                                end
                                state_reg <= S_DONE;
                            end
                            OP_DETACH: state_reg <= S_DET_SCAN;
                            OP_FIND:   state_reg <= S_FF_OUTER;
                            default:   state_reg <= S_DONE;
                        endcase
                    end
                end

                // detach: read every entry, keep the newest match
                S_DET_SCAN:
                begin
                    chk_vld_reg <= 1'b1;
                    chk_idx_reg <= j_reg;
                    if (j_reg == LAST)
                    begin
                        state_reg <= S_DET_TAIL;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_DET_TAIL: state_reg <= S_DET_FIN;
                S_DET_FIN:
                begin
                    if (hit_reg)
                    begin
                        for (int k = 0; k < MAX_REGIONS; k++)
                        begin
                            if (valid_reg[k] && rank_reg[k] > hit_rank_reg)
                            begin
                                rank_reg[k] <= rank_reg[k] - 1'b1;
                            end
                        end
                        valid_reg[hit_idx_reg] <= 1'b0;
                        rank_reg[hit_idx_reg]  <= '0;
                        p_ok_reg               <= 1'b1;
                        p_rel_reg              <= hit_obj_reg;
                    end
                    state_reg <= S_DONE;
                end

                // find free: pick the next candidate region
                S_FF_OUTER:
                begin
                    if (valid_reg[i_reg])
                    begin
                        state_reg <= S_FF_WAIT;
                    end
                    else if (i_reg == LAST)
                    begin
                        state_reg <= S_FF_EVAL;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_FF_WAIT:
                begin
                    if ({1'b0, rdata.base_addr} > len_reg)
                    begin
                        lo_reg    <= rdata.base_addr - len_reg[31:0];
                        hi_reg    <= rdata.base_addr - 32'd1;
                        clear_reg <= 1'b1;
                        j_reg     <= '0;
                        state_reg <= S_FF_INNER;
                    end
                    else if (i_reg == LAST)
                    begin
                        state_reg <= S_FF_EVAL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_FF_OUTER;
                    end
                end
                // test the span against every entry
                S_FF_INNER:
                begin
                    chk_vld_reg <= 1'b1;
                    chk_idx_reg <= j_reg;
                    if (j_reg == LAST)
                    begin
                        state_reg <= S_FF_TAIL;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_FF_TAIL:
                begin
                    state_reg <= S_FF_EVAL;
                end
                // keep the span if clear and highest; then next candidate or finish
                S_FF_EVAL:
                begin
                    if (clear_reg && lo_reg > best_reg)
                    begin
                        best_reg <= lo_reg;
                    end
                    clear_reg <= 1'b0;
                    if (i_reg == LAST)
                    begin
                        p_ok_reg   <= (clear_reg && lo_reg > best_reg) || (best_reg != 32'd0);
                        p_addr_reg <= (clear_reg && lo_reg > best_reg) ? lo_reg : best_reg;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_FF_OUTER;
                    end
                end

                // hand the result to the output register
                S_DONE:
                begin
                    if (res_free)
                    begin
                        res_valid_reg <= 1'b1;
                        res_ok_reg    <= p_ok_reg;
                        res_addr_reg  <= p_addr_reg;
                        res_rel_reg   <= p_rel_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = res_valid_reg;
    assign ok              = res_ok_reg;
    assign found_addr      = res_addr_reg;
    assign released_object = res_rel_reg;

    // a successful attach adds exactly one valid entry
    a_attach_fill: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> $countones(valid_reg) == $past($countones(valid_reg)) + 1)
        else $error("attach did not fill one slot");

    // entry memory is written only on an accepted attach
    a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE))
        else $error("memory write outside idle");

    // a found address or released object implies success
    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (found_addr != 32'd0 || released_object != 16'd0)) |-> ok)
        else $error("nonzero result without ok");

    // a successful detach removes exactly one entry
    a_detach_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DET_FIN && hit_reg)
        |=> $countones(valid_reg) + 1 == $past($countones(valid_reg)))
        else $error("detach did not free one slot");

endmodule

@@ sim/region_table_free_gap_finder_core_test.sv @@
// Self-checking bench for the region table core: directed and random attach/detach/find traffic.
`timescale 1ns / 1ps
module region_table_free_gap_finder_core_test;
    import rtfg_pkg::*;

    localparam int NREG = DEF_MAX_REGIONS;
    localparam longint PAGE = DEF_PAGE_BYTES;

    typedef struct packed {
        opcode_t     op;
        logic [31:0] rstart;
        logic [31:0] rend;
        logic [31:0] kind;
        logic [15:0] obj;
        logic [31:0] offs;
        logic [31:0] len;
    } request_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
        logic [15:0] released;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [31:0] region_start = '0, region_end = '0, region_kind = '0;
    logic [15:0] object_id = '0;
    logic [31:0] object_offset = '0, request_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        ok;
    logic [31:0] found_addr;
    logic [15:0] released_object;

    region_table_free_gap_finder_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .region_start(region_start), .region_end(region_end),
        .region_kind(region_kind), .object_id(object_id),
        .object_offset(object_offset), .request_length(request_length),
        .out_valid(out_valid), .out_stall(out_stall),
        .ok(ok), .found_addr(found_addr), .released_object(released_object)
    );

    // predictor copy of the region table
    logic [31:0] tbl_start [NREG];
    logic [31:0] tbl_end [NREG];
    logic [15:0] tbl_obj [NREG];
    logic        tbl_valid [NREG];
    int          tbl_rank [NREG];

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int       mismatches = 0;
    bit       stim_done = 0;
    bit       calm = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit span_clear(logic [31:0] lo, logic [31:0] hi);
        for (int i = 0; i < NREG; i++)
            if (tbl_valid[i] && !((tbl_start[i] < lo && tbl_end[i] < lo) ||
                                  (tbl_start[i] > hi && tbl_end[i] > hi)))
                return 0;
        return 1;
    endfunction

    // apply one request to the table model and return its answer
    function automatic answer_t table_apply(request_t r);
        answer_t a;
        int slot;
        int hit;
        int rk;
        longint len;
        logic [31:0] lo;
        a = '0;
        slot = -1;
        hit = -1;
        case (r.op)
            OP_ATTACH: begin
                for (int i = NREG - 1; i >= 0; i--)
                    if (!tbl_valid[i]) slot = i;
                if (slot >= 0) begin
                    for (int i = 0; i < NREG; i++)
                        if (tbl_valid[i]) tbl_rank[i]++;
                    tbl_start[slot] = r.rstart;
                    tbl_end[slot] = r.rend;
                    tbl_obj[slot] = r.obj;
                    tbl_valid[slot] = 1;
                    tbl_rank[slot] = 0;
                    a.ok = 1;
                end
            end
            OP_DETACH: begin
                for (int i = 0; i < NREG; i++)
                    if (tbl_valid[i] && tbl_start[i] == r.rstart &&
                        (hit < 0 || tbl_rank[i] < tbl_rank[hit]))
                        hit = i;
                if (hit >= 0) begin
                    rk = tbl_rank[hit];
                    a.released = tbl_obj[hit];
                    tbl_valid[hit] = 0;
                    tbl_rank[hit] = 0;
                    for (int i = 0; i < NREG; i++)
                        if (tbl_valid[i] && tbl_rank[i] > rk) tbl_rank[i]--;
                    a.ok = 1;
                end
            end
            OP_FIND: begin
                len = longint'(r.len);
                if (len == 0) len = PAGE;
                len = ((len + PAGE - 1) / PAGE) * PAGE;
                for (int i = 0; i < NREG; i++)
                    if (tbl_valid[i] && longint'(tbl_start[i]) > len) begin
                        lo = 32'(longint'(tbl_start[i]) - len);
                        if (span_clear(lo, tbl_start[i] - 32'd1) && lo > a.addr)
                            a.addr = lo;
                    end
                a.ok = (a.addr != 0);
            end
            default: ;
        endcase
        return a;
    endfunction

    // random request; addresses cluster so detach and gaps hit often
    function automatic request_t make_request(bit wellformed);
        request_t r;
        logic [31:0] base;
        r = '0;
        r.op = opcode_t'($urandom_range(wellformed ? 2 : 3, 0));
        base = {4'($urandom_range(15, 0)), 28'h0} + ($urandom_range(63, 0) << 12);
        r.rstart = ($urandom_range(3, 0) == 0) ? $urandom() : base;
        r.rend = ($urandom_range(7, 0) == 0) ? $urandom()
                 : r.rstart + ($urandom_range(8, 0) << 12) + $urandom_range(4095, 0);
        r.kind = $urandom();
        r.obj = 16'($urandom());
        r.offs = $urandom();
        case ($urandom_range(3, 0))
            0: r.len = $urandom();
            1: r.len = $urandom_range(4096, 0);
            default: r.len = $urandom_range(16, 0) << 12;
        endcase
        return r;
    endfunction

    function automatic request_t directed(opcode_t op, logic [31:0] s, logic [31:0] e,
                                          logic [31:0] l);
        request_t r;
        r = '0;
        r.op = op;
        r.rstart = s;
        r.rend = e;
        r.kind = s ^ 32'hA5A5_5A5A;
        r.obj = 16'(s >> 12) ^ 16'hFFFF;
        r.offs = ~e;
        r.len = l;
        return r;
    endfunction

    // stimulus
    initial begin
        request_t r;
        pending_reqs.push_back(directed(OP_FIND, 32'h1000, 0, 0));
        pending_reqs.push_back(directed(OP_DETACH, 32'h1000, 0, 0));
        pending_reqs.push_back(directed(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(directed(OP_ATTACH, 32'h0010_0000, 32'h0010_1FFF, 0));
        pending_reqs.push_back(directed(OP_ATTACH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        pending_reqs.push_back(directed(OP_ATTACH, 32'h0000_0000, 32'h0000_0FFF, 0));
        pending_reqs.push_back(directed(OP_ATTACH, 32'h8000_0000, 32'h7000_0000, 0));
        pending_reqs.push_back(directed(OP_FIND, 0, 0, 0));
        pending_reqs.push_back(directed(OP_FIND, 0, 0, 32'h0000_1001));
        pending_reqs.push_back(directed(OP_FIND, 0, 0, 32'hFFFF_FFFF));
        pending_reqs.push_back(directed(OP_FIND, 0, 0, 32'hFFFF_F000));
        pending_reqs.push_back(directed(OP_ATTACH, 32'h0010_0000, 32'h0010_0FFF, 0));
        pending_reqs.push_back(directed(OP_DETACH, 32'h0010_0000, 0, 0));
        pending_reqs.push_back(directed(OP_DETACH, 32'h8000_0000, 0, 0));
        pending_reqs.push_back(directed(OP_DETACH, 32'h1234_5678, 0, 0));
        // fill the table and overflow it, then run a find
        for (int i = 0; i < NREG + 1; i++)
            pending_reqs.push_back(directed(OP_ATTACH, 32'h0100_0000 + (i << 16),
                                            32'h0100_0FFF + (i << 16), 0));
        pending_reqs.push_back(directed(OP_FIND, 0, 0, 32'h0000_F000));
        for (int i = 0; i < 420; i++) begin
            r = make_request($urandom_range(9, 0) != 0);
            pending_reqs.push_back(r);
        end
    end

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (!in_valid || !in_stall) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99, 0) >= 18)) begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    expected_answers.push_back(table_apply(r));
                    in_valid <= 1'b1;
                    opcode <= r.op;
                    region_start <= r.rstart;
                    region_end <= r.rend;
                    region_kind <= r.kind;
                    object_id <= r.obj;
                    object_offset <= r.offs;
                    request_length <= r.len;
                end else begin
                    in_valid <= 1'b0;
                    if (pending_reqs.size() == 0) stim_done <= 1'b1;
                end
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(99, 0) < 18);
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            answer_t e;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer at %0t", $time);
            end else begin
                e = expected_answers.pop_front();
                if (ok !== e.ok || found_addr !== e.addr || released_object !== e.released) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp ok=%0b addr=%h rel=%h got ok=%0b addr=%h rel=%h",
                                 $time, e.ok, e.addr, e.released, ok, found_addr,
                                 released_object);
                end
            end
        end
    end

    // reset, idle-free stretch, end of run
    initial begin
        for (int i = 0; i < NREG; i++) begin
            tbl_valid[i] = 0;
            tbl_rank[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (20000) @(posedge clk);
        calm = 1;
        repeat (15000) @(posedge clk);
        calm = 0;
        wait (stim_done && expected_answers.size() == 0);
        repeat (NREG * (NREG + 4) + 20) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("region_table_free_gap_finder_core test passed");
        else
            $display("region_table_free_gap_finder_core test failed");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("region_table_free_gap_finder_core test failed");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/rtfg_pkg.sv
rtl/core/rtfg_mem.sv
rtl/core/region_table_free_gap_finder_core.sv
sim/region_table_free_gap_finder_core_test.sv
